// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the sorted set exclusion counter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition in one cycle implies a property in the next cycle
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== hdl/ssec_pkg.sv =====
// ----------------------------------------------------------------------------
// ssec_pkg
// Shared types and constants of the sorted set exclusion counter.
// ----------------------------------------------------------------------------
`default_nettype none

package ssec_pkg;

    // Store geometry and search tuning
    localparam int MAX_VALUES       = 1024;
    localparam int LINEAR_THRESHOLD = 16;
    localparam int ADDR_W           = $clog2(MAX_VALUES);
    localparam int CNT_W            = $clog2(MAX_VALUES + 1);
    localparam int VALUE_W          = 32;
    localparam int OUT_TDATA_W      = 24;

    // Action codes carried in tuser
    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_CHECK  = 2'd2;

    // Status of the search sequencer toward the top level
    typedef struct packed {
        logic             busy;
        logic             done;
        logic             hit;
        logic [CNT_W-1:0] pos;
    } t_srch_stat;

endpackage

`default_nettype wire

// ===== hdl/sorted_set_exclusion_counter_top.sv =====
// Timing: clear and append update the store at the transfer edge, no result; an append to a full
// store is dropped. A check takes a compare step, binary probes until one hits or the range is short,
// a linear scan of the short range with a closing step on a miss, and a retire step before tvalid.
// Throughput: clear and append one per cycle while no check is in progress; a check holds
// tready low until it retires, and it cannot retire while the result register is stalled.
// Reset: synchronous, active low; clears count, found count, search and output valid.
// ----------------------------------------------------------------------------
// sorted_set_exclusion_counter_top
// Sorted id store in a chain of cells with a hybrid binary/linear search and
// a running count of stored ids not yet found.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sorted_set_exclusion_counter_top
    import ssec_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire logic [VALUE_W-1:0]     i_s_axis_tdata,  // [31:0] vertex
    input  wire logic [1:0]             i_s_axis_tuser,  // [1:0] action
    input  wire logic                   i_s_axis_tlast,  // last_check
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    output logic      [OUT_TDATA_W-1:0] o_m_axis_tdata,  // [0] found, [11:1] position,
                                                         // [22:12] remaining, [23] zero
    output logic                        o_m_axis_tlast   // final_res
);

    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       r_fsf;
    logic [VALUE_W-1:0]     r_key;
    logic                   r_last;
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                   r_out_last;

    logic                  w_in_xfer;
    logic                  w_start;
    logic                  w_shift;
    logic                  w_ack;
    logic                  w_inc;
    logic [CNT_W-1:0]      w_fsf_new;
    logic [CNT_W-1:0]      w_rem;
    t_srch_stat            w_stat;
    logic [VALUE_W-1:0]    w_val [MAX_VALUES];
    logic [MAX_VALUES-1:0] w_eq;
    logic [MAX_VALUES-1:0] w_lt;

    // Input transfer and action decode
    assign o_s_axis_tready = !w_stat.busy;
    assign w_in_xfer = i_s_axis_tvalid && o_s_axis_tready;
    assign w_start   = w_in_xfer && (i_s_axis_tuser == ACT_CHECK);
    assign w_shift   = w_in_xfer && (i_s_axis_tuser == ACT_APPEND)
                       && (r_count < CNT_W'(MAX_VALUES));

    // Chain of cells: an append pushes the new id into cell 0
    for (genvar g = 0; g < MAX_VALUES; g++) begin : g_cell
        ssec_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_shift),
            .i_din   ((g == 0) ? i_s_axis_tdata : w_val[(g == 0) ? 0 : g - 1]),
            .i_key   (r_key),
            .o_value (w_val[g]),
            .o_eq    (w_eq[g]),
            .o_lt    (w_lt[g])
        );
    end

    ssec_search u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_count (r_count),
        .i_eq    (w_eq),
        .i_lt    (w_lt),
        .i_ack   (w_ack),
        .o_stat  (w_stat)
    );

    // Retire a finished search once the output slot is free
    assign w_ack     = w_stat.done && (!r_out_valid || i_m_axis_tready);
    assign w_inc     = w_stat.hit && (r_fsf < r_count);
    assign w_fsf_new = r_fsf + CNT_W'(w_inc);
    assign w_rem     = (r_count > w_fsf_new) ? (r_count - w_fsf_new) : '0;

    // Control state: count, found count, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_fsf       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_xfer) begin
                unique case (i_s_axis_tuser)
                    ACT_CLEAR: begin
                        r_count <= '0;
                        r_fsf   <= '0;
                    end
                    ACT_APPEND: begin
                        if (w_shift) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (w_ack) begin
                r_fsf <= r_last ? '0 : w_fsf_new;
            end
            if (w_ack) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: key, list end flag and the result word
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_key  <= i_s_axis_tdata;
            r_last <= i_s_axis_tlast;
        end
        if (w_ack) begin
            r_out_data <= {1'b0, w_rem, w_stat.pos, w_stat.hit};
            r_out_last <= r_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

    `ASSERT_ALWAYS(a_found_within_count, r_fsf <= r_count, "found count exceeds stored count")
    `ASSERT_NEXT(a_check_blocks_input, w_start, !o_s_axis_tready, "input open during a check")
    `ASSERT_NEXT(a_stall_holds_result, r_out_valid && !i_m_axis_tready, r_out_valid && $stable(r_out_data), "stalled result changed")

endmodule

`default_nettype wire

// ===== hdl/ssec_cell.sv =====
// ----------------------------------------------------------------------------
// ssec_cell
// One storage cell of the sorted value chain: holds one id, passes it to the
// next cell on an append, and registers its compare flags against the key.
// ----------------------------------------------------------------------------
`default_nettype none

module ssec_cell
    import ssec_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_shift,
    input  wire logic [VALUE_W-1:0] i_din,
    input  wire logic [VALUE_W-1:0] i_key,
    output logic      [VALUE_W-1:0] o_value,
    output logic                    o_eq,
    output logic                    o_lt
);

    logic [VALUE_W-1:0] r_value;
    logic               r_eq;
    logic               r_lt;

    // Take the neighbor's value on an append
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_value <= i_din;
        end
    end

    // Register the compare against the broadcast key
    always_ff @(posedge i_clk) begin
        r_eq <= (r_value == i_key);
        r_lt <= (r_value < i_key);
    end

    assign o_value = r_value;
    assign o_eq    = r_eq;
    assign o_lt    = r_lt;

endmodule

`default_nettype wire

// ===== hdl/ssec_search.sv =====
// ----------------------------------------------------------------------------
// ssec_search
// Search sequencer: binary search over the cell flags while the range is at
// least the threshold long, then a linear scan one index per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ssec_search
    import ssec_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [CNT_W-1:0]      i_count,
    input  wire logic [MAX_VALUES-1:0] i_eq,
    input  wire logic [MAX_VALUES-1:0] i_lt,
    input  wire logic                  i_ack,
    output t_srch_stat                 o_stat
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WAIT = 3'd1;
    localparam logic [2:0] S_BIN  = 3'd2;
    localparam logic [2:0] S_LIN  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_lo, n_lo;
    logic [CNT_W-1:0] r_hi, n_hi;
    logic [CNT_W-1:0] r_pos, n_pos;
    logic             r_hit, n_hit;

    logic [CNT_W:0]    w_sum;
    logic [CNT_W-1:0]  w_mid;
    logic [CNT_W-1:0]  w_span;
    logic [ADDR_W-1:0] w_mid_cell;
    logic [ADDR_W-1:0] w_lo_cell;
    logic              w_bin;

    // Index i of the sorted order sits in cell count-1-i
    assign w_sum      = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid      = w_sum[CNT_W:1];
    assign w_span     = r_hi - r_lo;
    assign w_bin      = 32'(w_span) >= LINEAR_THRESHOLD;
    assign w_mid_cell = ADDR_W'(i_count - w_mid - CNT_W'(1));
    assign w_lo_cell  = ADDR_W'(i_count - r_lo - CNT_W'(1));

    // Advance the search one probe or one scan step per cycle
    always_comb begin
        n_state = r_state;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_pos   = r_pos;
        n_hit   = r_hit;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_WAIT;
                    n_lo    = '0;
                    n_hi    = i_count;
                end
            end
            S_WAIT: begin
                n_state = S_BIN;
            end
            S_BIN: begin
                if (!w_bin) begin
                    n_state = S_LIN;
                end else if (i_eq[w_mid_cell]) begin
                    n_state = S_DONE;
                    n_hit   = 1'b1;
                    n_pos   = w_mid;
                end else if (i_lt[w_mid_cell]) begin
                    n_lo = w_mid + CNT_W'(1);
                end else begin
                    n_hi = w_mid;
                end
            end
            S_LIN: begin
                if (r_lo >= r_hi) begin
                    n_state = S_DONE;
                    n_hit   = 1'b0;
                    n_pos   = i_count;
                end else if (i_eq[w_lo_cell]) begin
                    n_state = S_DONE;
                    n_hit   = 1'b1;
                    n_pos   = r_lo;
                end else begin
                    n_lo = r_lo + CNT_W'(1);
                end
            end
            S_DONE: begin
                if (i_ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lo    <= '0;
            r_hi    <= '0;
            r_pos   <= '0;
            r_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_lo    <= n_lo;
            r_hi    <= n_hi;
            r_pos   <= n_pos;
            r_hit   <= n_hit;
        end
    end

    assign o_stat.busy = (r_state != S_IDLE);
    assign o_stat.done = (r_state == S_DONE);
    assign o_stat.hit  = r_hit;
    assign o_stat.pos  = r_pos;

    `ASSERT_ALWAYS(a_range_in_store, ((r_state != S_BIN) && (r_state != S_LIN)) || ((r_lo <= r_hi) && (r_hi <= i_count)), "search range outside the store")
    `ASSERT_ALWAYS(a_hit_pos_valid, (r_state != S_DONE) || (r_hit ? (r_pos < i_count) : (r_pos == i_count)), "search result position inconsistent")
    `ASSERT_NEXT(a_start_leaves_idle, (r_state == S_IDLE) && i_start, r_state == S_WAIT, "search did not start")

endmodule

`default_nettype wire
